### sv/tbra_pkg.sv
// Package for the tile bitmap rectangle allocator.
// Holds command, status and register index codes and bus widths; no dependencies.
`default_nettype none
package tbra_pkg;
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_TILE_W = 2'd0;
  localparam logic [1:0] REG_TILE_H = 2'd1;
  localparam logic [1:0] REG_EPOCH  = 2'd2;

  localparam int IN_BITS  = 72;
  localparam int OUT_BITS = 40;
endpackage
`default_nettype wire

### sv/tile_bitmap_rect_allocator.sv
// Tile bitmap rectangle allocator, top level with its sequencer and maps.
// Depends on tbra_pkg.
//
// One item at a time. Ceil-divisions and offsets go through one shared
// restoring divider (one restoring step per quotient bit, then a decision
// state; two quotients for an allocate, four for a check). Clear sweeps the
// maps one row a cycle. Allocate visits each candidate start row, ANDs ht
// rows read through the free-map port, then tests one column per cycle; at a
// hit it reads each of the ht rows and writes it back with the run cleared.
// Check reads up to ht damage rows. A reset starts the same clearing pass,
// and no item is accepted until it ends. Results wait in an output register,
// and the next item is accepted only after the result has been taken.
`default_nettype none
module tile_bitmap_rect_allocator #(
  parameter int ROW_BITS = 32,
  parameter int TILE_ROWS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd[1:0], width_px[14:2], height_px[30:15], rect_x[46:31], rect_y[62:47],
  // epoch_tag[70:63], zero fill above
  input  wire logic [tbra_pkg::IN_BITS-1:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pos_x[15:0], pos_y[31:16], status[33:32], zero fill above
  output logic [tbra_pkg::OUT_BITS-1:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import tbra_pkg::*;

  localparam int RW = $clog2(TILE_ROWS);
  localparam int CW = $clog2(ROW_BITS + 1);
  localparam int TW = $clog2(TILE_ROWS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_DECIDE, S_ROWRD, S_COL, S_WRITE, S_CHK, S_DONE
  } state_t;
  typedef enum logic [1:0] { D_W, D_H, D_X, D_Y } dsel_t;

  logic [ROW_BITS-1:0] free_mem [TILE_ROWS];
  logic [ROW_BITS-1:0] dmg_mem  [TILE_ROWS];

  state_t state_r;
  dsel_t  dsel_r;
  logic [7:0]  tw_r, th_r, epoch_r;
  logic [1:0]  cmd_r;
  logic [12:0] wpx_r;
  logic [15:0] hpx_r, rx_r, ry_r;
  logic [7:0]  etag_r;
  logic [16:0] dnum_r, quo_r;
  logic [7:0]  rem_r;
  logic [4:0]  dcnt_r;
  logic [16:0] wt_r, ht_r, xt_r, yt_r;
  logic [RW-1:0] row_r;
  logic [TW-1:0] k_r;
  logic [CW-1:0] col_r;
  logic [ROW_BITS-1:0] acc_r, mask_r;
  logic        rd_pend_r;
  logic [ROW_BITS-1:0] frd_r, drd_r;
  logic [RW-1:0] addr_r;
  logic        out_valid_r;
  logic [15:0] px_r, py_r;
  logic [1:0]  st_r;
  logic [23:0] mul_r;

  logic [7:0] tw_e, th_e, dden;
  logic [8:0] rtry;
  logic [16:0] dnum_in;
  assign tw_e = (tw_r == 8'd0) ? 8'd1 : tw_r;
  assign th_e = (th_r == 8'd0) ? 8'd1 : th_r;
  assign dden = (dsel_r == D_W || dsel_r == D_X) ? tw_e : th_e;
  // One restoring step: shift in the next numerator bit, subtract if it fits.
  assign rtry = {rem_r, dnum_r[16]} - {1'b0, dden};

  function automatic logic [16:0] div_num(dsel_t s, logic [12:0] w, logic [15:0] h,
                                          logic [15:0] x, logic [15:0] y,
                                          logic [7:0] tw, logic [7:0] th);
    unique case (s)
      D_W: div_num = {4'd0, w} + {9'd0, tw} - 17'd1;
      D_H: div_num = {1'b0, h} + {9'd0, th} - 17'd1;
      D_X: div_num = {1'b0, x};
      default: div_num = {1'b0, y};
    endcase
  endfunction

  logic [ROW_BITS-1:0] run_m;
  always_comb begin
    run_m = '1;
    run_m = ~(run_m >> wt_r[CW-1:0]);
  end

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(OUT_BITS-34){1'b0}}, st_r, py_r, px_r};

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      frd_r <= free_mem[addr_r];
      drd_r <= dmg_mem[addr_r];
    end
    if (state_r == S_CLR) begin
      free_mem[addr_r] <= '1;
      dmg_mem[addr_r]  <= '1;
    end else if (state_r == S_WRITE && !rd_pend_r) begin
      free_mem[addr_r] <= frd_r & ~mask_r;
      dmg_mem[addr_r]  <= drd_r & ~mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      addr_r <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r <= 1'b0;
      tw_r <= 8'd16;
      th_r <= 8'd16;
      epoch_r <= 8'd0;
      dsel_r <= D_W;
      cmd_r <= CMD_ALLOC;
      st_r <= ST_OK;
      px_r <= '0;
      py_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TILE_W: tw_r <= cfg_data;
          REG_TILE_H: th_r <= cfg_data;
          REG_EPOCH:  epoch_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          if (addr_r == RW'(TILE_ROWS - 1)) begin
            // The pass after a reset gives no result; a clear item does.
            if (cmd_r == CMD_CLEAR) begin
              out_valid_r <= 1'b1;
            end
            state_r <= S_IDLE;
          end
          addr_r <= addr_r + 1'b1;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r  <= in_tdata[1:0];
            wpx_r  <= in_tdata[14:2];
            hpx_r  <= in_tdata[30:15];
            rx_r   <= in_tdata[46:31];
            ry_r   <= in_tdata[62:47];
            etag_r <= in_tdata[70:63];
            px_r <= '0;
            py_r <= '0;
            if (in_tdata[1:0] == CMD_CLEAR) begin
              st_r <= ST_OK;
              addr_r <= '0;
              state_r <= S_CLR;
            end else if (in_tdata[1:0] == CMD_ALLOC || in_tdata[1:0] == CMD_CHECK) begin
              st_r <= ST_OK;
              dsel_r <= D_W;
              dnum_r <= div_num(D_W, in_tdata[14:2], 16'd0, 16'd0, 16'd0, tw_e, th_e);
              rem_r <= '0;
              dcnt_r <= '0;
              state_r <= S_DIV;
            end else begin
              st_r <= ST_RANGE;
              state_r <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (rtry[8]) rem_r <= {rem_r[6:0], dnum_r[16]};
          else rem_r <= rtry[7:0];
          dnum_r <= {dnum_r[15:0], ~rtry[8]};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 5'd16) begin
            quo_r <= {dnum_r[15:0], ~rtry[8]};
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          unique case (dsel_r)
            D_W: wt_r <= quo_r;
            D_H: ht_r <= quo_r;
            D_X: xt_r <= quo_r;
            default: yt_r <= quo_r;
          endcase
          if (dsel_r != D_Y && !(dsel_r == D_H && cmd_r == CMD_ALLOC)) begin
            dsel_r <= dsel_t'(dsel_r + 2'd1);
            dnum_r <= div_num(dsel_t'(dsel_r + 2'd1), wpx_r, hpx_r, rx_r, ry_r, tw_e, th_e);
            rem_r <= '0;
            dcnt_r <= '0;
            state_r <= S_DIV;
          end else if (cmd_r == CMD_ALLOC) begin
            if (wt_r == 17'd0 || quo_r == 17'd0 || wt_r > 17'(ROW_BITS)
                || quo_r > 17'(TILE_ROWS)) begin
              st_r <= ST_RANGE;
              state_r <= S_DONE;
            end else begin
              row_r <= '0;
              k_r <= '0;
              acc_r <= '1;
              addr_r <= '0;
              rd_pend_r <= 1'b1;
              state_r <= S_ROWRD;
            end
          end else if (etag_r == epoch_r) begin
            state_r <= S_DONE;
          end else if (wt_r == 17'd0 || ht_r == 17'd0
                       || {1'b0, xt_r} + {1'b0, wt_r} > 18'(ROW_BITS)
                       || {1'b0, quo_r} + {1'b0, ht_r} > 18'(TILE_ROWS)) begin
            st_r <= ST_RANGE;
            state_r <= S_DONE;
          end else begin
            mask_r <= run_m >> xt_r[CW-1:0];
            k_r <= '0;
            addr_r <= quo_r[RW-1:0];
            rd_pend_r <= 1'b1;
            state_r <= S_CHK;
          end
        end
        S_ROWRD: begin
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
          end else if (17'(k_r) == ht_r) begin
            col_r <= '0;
            mask_r <= run_m;
            state_r <= S_COL;
          end else begin
            acc_r <= acc_r & frd_r;
            k_r <= k_r + 1'b1;
            addr_r <= addr_r + 1'b1;
            if (17'(k_r) + 17'd1 != ht_r) rd_pend_r <= 1'b1;
          end
        end
        S_COL: begin
          if ((acc_r & mask_r) == mask_r) begin
            mul_r <= 24'(col_r) * 24'(tw_e);
            k_r <= '0;
            addr_r <= row_r;
            rd_pend_r <= 1'b1;
            state_r <= S_WRITE;
          end else if (32'(col_r) + 32'(wt_r) >= 32'(ROW_BITS)) begin
            if (32'(row_r) + 32'(ht_r) >= 32'(TILE_ROWS)) begin
              st_r <= ST_FAIL;
              state_r <= S_DONE;
            end else begin
              row_r <= row_r + 1'b1;
              addr_r <= row_r + 1'b1;
              k_r <= '0;
              acc_r <= '1;
              rd_pend_r <= 1'b1;
              state_r <= S_ROWRD;
            end
          end else begin
            col_r <= col_r + 1'b1;
            mask_r <= mask_r >> 1;
          end
        end
        S_WRITE: begin
          if (k_r == '0 && rd_pend_r) px_r <= mul_r[15:0];
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
          end else begin
            k_r <= k_r + 1'b1;
            addr_r <= addr_r + 1'b1;
            if (17'(k_r) + 17'd1 == ht_r) begin
              mul_r <= 24'(row_r) * 24'(th_e);
              state_r <= S_DONE;
              cmd_r <= CMD_CHECK;
            end else begin
              rd_pend_r <= 1'b1;
            end
          end
        end
        S_CHK: begin
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
          end else if ((drd_r & mask_r) != mask_r) begin
            st_r <= ST_FAIL;
            state_r <= S_DONE;
          end else if (17'(k_r) + 17'd1 == ht_r) begin
            state_r <= S_DONE;
          end else begin
            k_r <= k_r + 1'b1;
            addr_r <= addr_r + 1'b1;
            rd_pend_r <= 1'b1;
          end
        end
        S_DONE: begin
          // After an allocate hit, the row product lands here.
          if (cmd_r == CMD_CHECK && st_r == ST_OK && px_r != 16'hFFFF && state_r == S_DONE
              && wt_r != 17'd0 && dsel_r == D_H) begin
            py_r <= mul_r[15:0];
          end
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
